// ----- rtl/swtq_pkg.sv -----
// Shared types and codes for the sorted wake-up timer queue.
package swtq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_WOKEN = 2'd1;
    localparam logic [1:0] KIND_IDLE  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SLEEP = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [7:0]         thread_id;
        logic signed [31:0] sleep_ticks;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  woken_id;
        logic [1:0]  status;
        logic [62:0] tick_now;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [63:0] wake;
        logic [7:0]  id;
    } t_entry;

endpackage

// ----- rtl/swtq_mem.sv -----
// Queue entry storage: one write port, one registered read port.
module swtq_mem #(
    parameter int DEPTH = swtq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  swtq_pkg::t_entry      i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output swtq_pkg::t_entry      o_rdata
);
    import swtq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sorted_wakeup_timer_queue_core.sv -----
// Top level of the sorted wake-up timer queue: sequencer, tick counter, output register.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): a request is either a
// tick or a sleep request. Output channel (o_out_valid / i_out_stall /
// o_out_data): every request gives one or more results, the final one with
// last set. A sleep request gives one acknowledgment; a tick gives one result
// per woken thread (at most MAX_RESULTS) or one idle result.
// Entries live in a circular buffer memory with a single registered read port,
// walked by one compare unit, a read and then a compare for each entry.
// After a request is taken, o_in_stall stays high until the sequencer is back
// in S_IDLE: an ignored or dropped sleep request goes straight to S_EMIT; an
// insert passes S_INS_RD and S_INS_CMP for each entry that it moves; a tick
// passes S_POP_RD and S_POP_CMP for each entry it checks and S_EMIT for each
// result. Each result is valid in the cycle after the S_EMIT that loads it.
// The last result sits in the output register, so the next request is taken
// while it still waits. When the receiver stalls, the sequencer holds in
// S_EMIT before loading its next result, until the output register is free.
// Reset (i_rst_n low, synchronous) clears the tick counter and empties the
// queue; no memory clearing pass is needed.
module sorted_wakeup_timer_queue_core #(
    parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  swtq_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output swtq_pkg::t_out_item   o_out_data
);
    import swtq_pkg::*;

    localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int NPW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_POP_RD,
        S_POP_CMP,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [63:0]      r_tick;
    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_occ;
    logic [CW-1:0]    r_idx;
    logic [NPW-1:0]   r_npop;
    logic [63:0]      r_wake;
    logic [7:0]       r_id;
    logic [7:0]       r_pend_id;
    logic             r_have_pend;
    t_out_item        r_res;
    t_out_item        r_out;
    logic             r_out_valid;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    t_entry           mem_wdata;
    t_entry           mem_rdata;
    t_entry           new_entry;
    logic [64:0]      wake_sum;
    logic [63:0]      wake_sat;
    logic             slot_free;
    logic             in_accept;
    logic             more_due;
    t_out_item        final_res;
    t_out_item        n_out;
    logic             n_out_valid;

    function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return AW'(s);
    endfunction

    swtq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_accept = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign new_entry = '{wake: r_wake, id: r_id};
    assign wake_sum  = {1'b0, r_tick} + {33'b0, i_in_data.sleep_ticks[31:0]};
    assign wake_sat  = wake_sum[64] ? {64{1'b1}} : wake_sum[63:0];
    assign more_due  = (r_occ != '0) && (r_npop != NPW'(MAX_RESULTS));
    assign n_out_valid = ((r_state == S_EMIT) && slot_free) || (r_out_valid && i_out_stall);

    always_comb begin
        n_out          = r_res;
        n_out.tick_now = r_tick[62:0];
    end

    always_comb begin
        final_res = '0;
        final_res.last = 1'b1;
        final_res.status = ST_OK;
        if (r_have_pend) begin
            final_res.kind     = KIND_WOKEN;
            final_res.woken_id = r_pend_id;
        end else begin
            final_res.kind     = KIND_IDLE;
            final_res.woken_id = 8'd0;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_head;
        mem_wdata = new_entry;
        mem_raddr = r_head;
        unique case (r_state)
            S_INS_RD: begin
                if (r_idx == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_head;
                end else begin
                    mem_raddr = addr_add(r_head, CW'(r_idx - 1'b1));
                end
            end
            S_INS_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = addr_add(r_head, r_idx);
                mem_wdata = (mem_rdata.wake > r_wake) ? mem_rdata : new_entry;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_head      <= '0;
            r_occ       <= '0;
            r_idx       <= '0;
            r_npop      <= '0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_in_data.operation == OP_SLEEP) begin
                            r_res.kind     <= KIND_ACK;
                            r_res.woken_id <= i_in_data.thread_id;
                            r_res.last     <= 1'b1;
                            r_id           <= i_in_data.thread_id;
                            r_wake         <= wake_sat;
                            r_idx          <= r_occ;
                            if (i_in_data.sleep_ticks <= 32'sd0) begin
                                r_res.status <= ST_IGNORED;
                                r_state      <= S_EMIT;
                            end else if (r_occ == CW'(QUEUE_DEPTH)) begin
                                r_res.status <= ST_FULL;
                                r_state      <= S_EMIT;
                            end else begin
                                r_res.status <= ST_OK;
                                r_state      <= S_INS_RD;
                            end
                        end else begin
                            r_tick      <= r_tick + 64'd1;
                            r_npop      <= '0;
                            r_have_pend <= 1'b0;
                            r_state     <= S_POP_RD;
                        end
                    end
                end
                S_INS_RD: begin
                    if (r_idx == '0) begin
                        r_occ   <= r_occ + 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (mem_rdata.wake > r_wake) begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_INS_RD;
                    end else begin
                        r_occ   <= r_occ + 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_POP_RD: begin
                    if (more_due) begin
                        r_state <= S_POP_CMP;
                    end else begin
                        r_res   <= final_res;
                        r_state <= S_EMIT;
                    end
                end
                S_POP_CMP: begin
                    if (mem_rdata.wake <= r_tick) begin
                        r_head      <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        r_occ       <= r_occ - 1'b1;
                        r_npop      <= r_npop + 1'b1;
                        r_pend_id   <= mem_rdata.id;
                        r_have_pend <= 1'b1;
                        if (r_have_pend) begin
                            r_res.kind     <= KIND_WOKEN;
                            r_res.woken_id <= r_pend_id;
                            r_res.status   <= ST_OK;
                            r_res.last     <= 1'b0;
                            r_state        <= S_EMIT;
                        end else begin
                            r_state <= S_POP_RD;
                        end
                    end else begin
                        r_res   <= final_res;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out   <= n_out;
                        r_state <= r_res.last ? S_IDLE : S_POP_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_CMP) |-> (r_occ != '0))
        else $error("pop compare on empty queue");

    a_pop_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_npop <= NPW'(MAX_RESULTS))
        else $error("too many wakeups in one tick");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.operation == OP_TICK) |=> (r_tick == $past(r_tick) + 64'd1))
        else $error("tick counter did not advance");

endmodule
